[rtl/core/qmgpc_pkg.sv]
// Shared types, constants and the modular adder of the queen-move path counter.
package qmgpc_pkg;

  // Width of one path count and of every running sum.
  localparam int COUNT_W = 30;

  // Width of the row length register.
  localparam int ROW_LEN_W = 12;

  // Default depth of the line memories (largest supported row).
  localparam int MAX_COLS_DEF = 2048;

  // Counts are kept modulo this prime.
  localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

  // Row length after reset.
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 12'd2048;

  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [ROW_LEN_W-1:0] row_len_t;

  // Sum of two residues, reduced once: both inputs are below the modulus.
  function automatic count_t add_mod(count_t a, count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

[rtl/core/qmgpc_line_ram.sv]
// One-write, one-read line memory with a registered read port.
module qmgpc_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/qmgpc_col_track.sv]
// Column and top-row tracking for cells as they are accepted in raster order.
module qmgpc_col_track #(
  parameter int MAX_COLS = qmgpc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        grid_start,
  input  qmgpc_pkg::row_len_t         row_length,
  output logic [$clog2(MAX_COLS)-1:0] col,
  output logic                        first_row
);
  import qmgpc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int LW = $clog2(MAX_COLS + 1);

  logic [CW-1:0] column_r;
  logic          first_row_r;
  logic [LW-1:0] len;
  logic [LW-1:0] col_inc;
  logic          wrap;

  // A row length of zero or beyond the memory depth means the full depth.
  always_comb begin
    if (row_length == '0 || 32'(row_length) > 32'(MAX_COLS)) begin
      len = LW'(MAX_COLS);
    end else begin
      len = LW'(row_length);
    end
  end

  // A start cell restarts the grid at column zero of the top row.
  assign col       = grid_start ? '0 : column_r;
  assign first_row = grid_start | first_row_r;
  assign col_inc   = LW'(col) + LW'(1);
  assign wrap      = (col_inc >= len);

  // Advance the position once per accepted cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (adv) begin
      if (wrap) begin
        column_r    <= '0;
        first_row_r <= 1'b0;
      end else begin
        column_r    <= col_inc[CW-1:0];
        first_row_r <= first_row;
      end
    end
  end

endmodule

[rtl/core/queen_move_grid_path_count_unit.sv]
// Top level of the queen-move path counter: line memories, count stage and output register.
//
//   Channel  Ports                                 Direction  Carries
//   in       in_valid/in_ready, in_blocked,        input      one grid cell
//            in_grid_start
//   out      out_valid/out_ready, out_path_count   output     path count of that cell
//   cfg      cfg_valid/cfg_ready, cfg_row_length   input      row length register
//
// One cell per cycle is sustained while the output is taken; at acceptance the line
// memories are read and the count stage is loaded, and the count stage then loads the output register.
// Synchronous active-low reset clears the position, the running sums and both
// valid flags; the line memories are not cleared and need no clearing pass.
// A stalled output holds the count stage, and the input stalls only when both are full.
// The configuration port is always ready.
module queen_move_grid_path_count_unit #(
  parameter int MAX_COLS = qmgpc_pkg::MAX_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_blocked,
  input  logic                in_grid_start,
  output logic                out_valid,
  input  logic                out_ready,
  output qmgpc_pkg::count_t   out_path_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  qmgpc_pkg::row_len_t cfg_row_length
);
  import qmgpc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  // Configuration register.
  row_len_t row_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_length_r <= cfg_row_length;
    end
  end

  // Handshake and stage control.
  logic          acc;
  logic          b_adv;
  logic          b_valid_r;
  logic          out_valid_r;
  count_t        out_count_r;
  logic [CW-1:0] col_a;
  logic          first_a;

  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_adv;
  assign acc      = in_valid && in_ready;

  qmgpc_col_track #(
    .MAX_COLS (MAX_COLS)
  ) u_col_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (acc),
    .grid_start (in_grid_start),
    .row_length (row_length_r),
    .col        (col_a),
    .first_row  (first_a)
  );

  // Count stage registers, loaded at acceptance while the memories are read.
  logic          b_blocked_r;
  logic          b_start_r;
  logic          b_first_r;
  logic [CW-1:0] b_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (acc) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_blocked_r <= in_blocked;
      b_start_r   <= in_grid_start;
      b_first_r   <= first_a;
      b_col_r     <= col_a;
    end
  end

  // Line memories of the previous row's vertical and diagonal sums.
  count_t vert_rd;
  count_t diag_rd;
  count_t new_left;
  count_t new_vert;
  count_t new_diag;

  qmgpc_line_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (COUNT_W)
  ) u_vert_ram (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_col_r),
    .wdata (new_vert),
    .re    (acc),
    .raddr (col_a),
    .rdata (vert_rd)
  );

  qmgpc_line_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (COUNT_W)
  ) u_diag_ram (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_col_r),
    .wdata (new_diag),
    .re    (acc),
    .raddr (col_a),
    .rdata (diag_rd)
  );

  // Bypass for a read that meets a write to the same column in the same cycle
  // (a single-column row, or a start cell just after a column-zero cell).
  logic   fwd_r;
  count_t fwd_vert_r;
  count_t fwd_diag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (acc) begin
      fwd_r <= b_adv && (col_a == b_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_vert_r <= new_vert;
      fwd_diag_r <= new_diag;
    end
  end

  count_t vert_val;
  count_t diag_val;

  assign vert_val = fwd_r ? fwd_vert_r : vert_rd;
  assign diag_val = fwd_r ? fwd_diag_r : diag_rd;

  // Running sums carried from cell to cell.
  count_t left_sum_r;
  count_t diag_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r  <= '0;
      diag_held_r <= '0;
    end else if (b_adv) begin
      left_sum_r  <= new_left;
      diag_held_r <= diag_val;
    end
  end

  // Path count of the cell and the sums it passes on.
  count_t up;
  count_t upleft;
  count_t left;
  count_t count;

  always_comb begin
    up     = b_first_r ? '0 : vert_val;
    upleft = (b_first_r || b_col_r == '0) ? '0 : diag_held_r;
    left   = (b_col_r == '0) ? '0 : left_sum_r;
    priority if (b_start_r) begin
      count    = COUNT_W'(1);
      new_left = COUNT_W'(1);
      new_vert = COUNT_W'(1);
      new_diag = COUNT_W'(1);
    end else if (b_blocked_r) begin
      count    = '0;
      new_left = '0;
      new_vert = '0;
      new_diag = '0;
    end else begin
      count    = add_mod(add_mod(up, left), upleft);
      new_left = add_mod(count, left);
      new_vert = add_mod(count, up);
      new_diag = add_mod(count, upleft);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_count_r <= count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_path_count = out_count_r;

  // Every delivered count is a reduced residue.
  a_count_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r < PATH_MOD))
    else $error("path count not reduced modulo the prime");

  // With the output register free the block always takes a new cell.
  a_ready_when_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with the output register empty");

  // A start cell always enters the count stage at column zero in the top row.
  a_start_at_origin : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_grid_start) |=> (b_col_r == '0 && b_first_r))
    else $error("start cell not placed at the grid origin");

  // The bypass fires whenever the same column was written in the read cycle.
  a_bypass_same_col : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && b_adv && (col_a == b_col_r)) |=> fwd_r)
    else $error("same-column read missed the write bypass");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the queen-move grid path counter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qmgpc_pkg::*;

  localparam int LINE_DEPTH  = MAX_COLS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CELLS = 720;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  logic     in_blocked = 1'b0;
  logic     in_grid_start = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  count_t   out_path_count;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  row_len_t cfg_row_length = ROW_LEN_RESET;

  // Mirror of the block's state, kept by the path count predictor.
  bit [COUNT_W-1:0] vert_sums [LINE_DEPTH];
  bit [COUNT_W-1:0] diag_sums [LINE_DEPTH];
  count_t           row_sum = '0;
  count_t           held_diag = '0;
  int unsigned      next_col = 0;
  bit               top_row = 1'b1;
  row_len_t         row_len_reg = ROW_LEN_RESET;

  // Path counts still owed by the block, oldest first.
  count_t counts_due [$];

  bit          no_gaps = 1'b0;
  int unsigned n_cells = 0;
  int unsigned n_grids = 0;
  int unsigned n_len_writes = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;

  queen_move_grid_path_count_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_blocked     (in_blocked),
    .in_grid_start  (in_grid_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_path_count (out_path_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_row_length (cfg_row_length)
  );

  // Free-running clock.
  always #6 clk = ~clk;

  // Run limit: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d counts outstanding", $time,
               counts_due.size());
      $display("** queen_move_grid_path_count_unit: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure, dropped now and then unless a steady stretch is running.
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 14);
  end

  // Sum of two residues below the modulus, reduced once.
  function automatic count_t sum_mod(count_t a, count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    return s[COUNT_W-1:0];
  endfunction

  // Works out one cell's path count and advances the mirrored running sums.
  function automatic count_t predict_path_count(bit blocked, bit start);
    int unsigned len;
    int unsigned col;
    count_t      up;
    count_t      upleft;
    count_t      left;
    count_t      count;
    count_t      new_left;
    count_t      new_vert;
    count_t      new_diag;
    count_t      next_held;
    len = (row_len_reg == '0 || row_len_reg > LINE_DEPTH) ? LINE_DEPTH : row_len_reg;
    if (start) begin
      next_col = 0;
      top_row  = 1'b1;
    end
    col = (next_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : next_col;
    up        = top_row ? '0 : vert_sums[col];
    upleft    = (top_row || col == 0) ? '0 : held_diag;
    left      = (col == 0) ? '0 : row_sum;
    next_held = diag_sums[col];
    if (start) begin
      count    = 'd1;
      new_left = 'd1;
      new_vert = 'd1;
      new_diag = 'd1;
    end else if (blocked) begin
      count    = '0;
      new_left = '0;
      new_vert = '0;
      new_diag = '0;
    end else begin
      count    = sum_mod(sum_mod(up, left), upleft);
      new_left = sum_mod(count, left);
      new_vert = sum_mod(count, up);
      new_diag = sum_mod(count, upleft);
    end
    row_sum        = new_left;
    vert_sums[col] = new_vert;
    diag_sums[col] = new_diag;
    held_diag      = next_held;
    if (col + 1 >= len) begin
      next_col = 0;
      top_row  = 1'b0;
    end else begin
      next_col = col + 1;
    end
    return count;
  endfunction

  // Compare each result transaction with the oldest owed count.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (counts_due.size() == 0) begin
        $display("%0t: path count %0d arrived with none expected", $time, out_path_count);
        n_errors <= n_errors + 1;
      end else begin
        if (out_path_count !== counts_due[0]) begin
          $display("%0t: path count mismatch: expected %0d, actual %0d", $time,
                   counts_due[0], out_path_count);
          n_errors <= n_errors + 1;
        end
        void'(counts_due.pop_front());
        n_checked <= n_checked + 1;
      end
    end
  end

  // Send one cell as an input transaction and record its expected count once accepted.
  task automatic send_cell(bit blocked, bit start);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_blocked    <= blocked;
    in_grid_start <= start;
    do begin
      @(posedge clk);
    end while (!in_ready);
    counts_due.push_back(predict_path_count(blocked, start));
    n_cells++;
    if (start) begin
      n_grids++;
    end
  endtask

  // Stop sending and wait until every owed count has come back.
  task automatic drain_counts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (counts_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the row length register once the block has drained and is idle.
  task automatic write_row_length(row_len_t len);
    drain_counts();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_row_length <= len;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    row_len_reg = len;
    n_len_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Cells before any grid start are counted as an ordinary grid whose sums are all zero.
  task automatic test_headless_stream();
    write_row_length(12'd2048);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
  endtask

  // A start cell flagged as blocked still counts one, and a wall clears the sums.
  task automatic test_blocked_start();
    write_row_length(12'd3);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
  endtask

  // One column: only the vertical sum carries from cell to cell.
  task automatic test_single_column();
    write_row_length(12'd1);
    send_cell(1'b0, 1'b1);
    send_cell(1'b0, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
  endtask

  // Shortening the row mid-grid past the current column ends the row after the next cell.
  task automatic test_midgrid_shrink();
    write_row_length(12'd6);
    send_cell(1'b0, 1'b1);
    repeat (3) send_cell(1'b0, 1'b0);
    write_row_length(12'd3);
    repeat (7) send_cell(1'b0, 1'b0);
  endtask

  // Widest rows: out-of-range lengths act as the full line depth along a long top row.
  task automatic test_widest_rows();
    write_row_length(12'd4095);
    send_cell(1'b0, 1'b1);
    repeat (200) send_cell($urandom_range(99) < 3, 1'b0);
    write_row_length(12'd0);
    no_gaps = 1'b1;
    repeat (200) send_cell($urandom_range(99) < 3, 1'b0);
    drain_counts();
    no_gaps = 1'b0;
  endtask

  // Random grids of random shapes, with some cut short and some with stray restarts.
  task automatic test_random_grids();
    int unsigned first_cell;
    int unsigned phase;
    int unsigned len;
    int unsigned pick;
    int unsigned rows;
    int unsigned cells;
    bit          blocked;
    bit          start;
    first_cell = n_cells;
    phase = 0;
    while (n_cells - first_cell < RANDOM_CELLS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = 1;
      end else if (pick < 12) begin
        len = $urandom_range(100, 300);
      end else begin
        len = $urandom_range(2, 24);
      end
      write_row_length(row_len_t'(len));
      no_gaps = (phase == 3);
      repeat ($urandom_range(1, 3)) begin
        rows  = $urandom_range(1, (len > 24) ? 2 : 14);
        cells = rows * len;
        if ($urandom_range(99) < 12) begin
          cells = $urandom_range(1, cells);
        end
        for (int unsigned i = 0; i < cells && n_cells - first_cell < RANDOM_CELLS; i++) begin
          start   = (i == 0);
          blocked = ($urandom_range(99) < 8);
          if (i != 0 && $urandom_range(99) < 3) begin
            start   = $urandom_range(1);
            blocked = $urandom_range(1);
          end
          send_cell(blocked, start);
        end
      end
      phase++;
    end
    drain_counts();
    no_gaps = 1'b0;
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_headless_stream();
    test_blocked_start();
    test_single_column();
    test_midgrid_shrink();
    test_widest_rows();
    test_random_grids();
    drain_counts();
    repeat (10) @(posedge clk);
    if (counts_due.size() != 0) begin
      $display("%0t: %0d path counts never arrived", $time, counts_due.size());
      n_errors++;
    end
    $display("Sent %0d cells in %0d grids under %0d row length settings.",
             n_cells, n_grids, n_len_writes);
    $display("Checked %0d path counts, %0d errors.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("** queen_move_grid_path_count_unit: PASSED **");
    end else begin
      $display("** queen_move_grid_path_count_unit: FAILED **");
    end
    $finish;
  end

endmodule
